FILE: rtl/crc16_maxim_packet_framer_core_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef CRC16_MAXIM_PACKET_FRAMER_CORE_MACROS_SVH
`define CRC16_MAXIM_PACKET_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CMPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CMPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cmpf_pkg.sv
// Types, codes and CRC-16/MAXIM lookup tables for the packet framer.
package cmpf_pkg;

  // Input opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_STRAY    = 2'd2;

  // Most result beats that one input beat can cause.
  localparam int unsigned NUM_RES = 6;
  localparam int unsigned CNT_W   = $clog2(NUM_RES + 1);

  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

  typedef logic [15:0] crc_tab_t [256];

  // Bitwise reflected CRC update over one byte; used only to build the tables.
  function automatic logic [15:0] crc_byte_bits(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Table entry i is the CRC, from zero, of byte i followed by a number of zero bytes.
  function automatic crc_tab_t crc_tab_gen(input int unsigned zeros);
    crc_tab_t    tab;
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = crc_byte_bits(16'h0000, 8'(i));
      for (int unsigned z = 0; z < zeros; z++) begin
        c = crc_byte_bits(c, 8'h00);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  // CRC_T0 is the usual byte table; the others give a header byte's share of
  // the header CRC according to how many header bytes follow it.
  localparam crc_tab_t CRC_T0 = crc_tab_gen(0);
  localparam crc_tab_t CRC_T1 = crc_tab_gen(1);
  localparam crc_tab_t CRC_T2 = crc_tab_gen(2);
  localparam crc_tab_t CRC_T3 = crc_tab_gen(3);

endpackage

FILE: rtl/cmpf_if.sv
// Valid/ready channel interfaces for the framer's input and result beats.
interface cmpf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  feature;
  logic [7:0]  command;
  logic [15:0] frame_length;
  logic [7:0]  payload_byte;

  modport source (
    output valid, opcode, feature, command, frame_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, feature, command, frame_length, payload_byte,
    output ready
  );
endinterface

interface cmpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [1:0] status;

  modport source (
    output valid, out_byte, frame_end, status,
    input  ready
  );
  modport sink (
    input  valid, out_byte, frame_end, status,
    output ready
  );
endinterface

FILE: rtl/crc16_maxim_packet_framer_core.sv
// CRC-16/MAXIM packet framer top level. A start beat (opcode 0) emits the
// four header bytes (feature, command, length high, length low); each data
// beat (opcode 1) emits one payload byte, and the last one is followed by the
// CRC high then low byte, with frame_end set on the low byte. A start beat with
// a zero length emits header and CRC at once. A length above MAX_PAYLOAD, or a
// data beat outside a frame, gives one error beat with out_byte zero and
// frame_end set. Every input beat is worked out in its accept cycle into a
// result buffer of up to six beats that drains one beat per cycle while
// output ready is high, so the input takes one payload beat per cycle when
// the output does not stall; a beat with more result beats holds the input
// until the buffer is down to its last beat. Input ready follows output
// ready when a single result beat is left. There are no registers to set up.
`include "crc16_maxim_packet_framer_core_macros.svh"

module crc16_maxim_packet_framer_core
  import cmpf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input logic        clk,
  input logic        rst_n,
  cmpf_in_if.sink    in_ch,
  cmpf_out_if.source out_ch
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  // Result buffer and framing state.
  res_t             rbuf_r   [NUM_RES];
  res_t             rbuf_nxt [NUM_RES];
  logic [CNT_W-1:0] rcnt_r;
  logic [CNT_W-1:0] rcnt_nxt;
  logic [15:0]      crc_r;
  logic [15:0]      crc_nxt;
  logic [15:0]      bytes_left_r;
  logic [15:0]      bytes_left_nxt;
  logic             in_frame_r;
  logic             in_frame_nxt;

  // Results of the beat on the input.
  res_t             new_res [NUM_RES];
  logic [CNT_W-1:0] new_cnt;

  logic        acc;
  logic        pop;
  logic [15:0] hdr_crc;
  logic [15:0] hdr_fin;
  logic [15:0] dat_crc;
  logic [15:0] dat_fin;
  logic [15:0] bl_dec;

  // Handshakes: the output shows the head of the buffer.
  assign acc             = in_ch.valid && in_ch.ready;
  assign pop             = out_ch.valid && out_ch.ready;
  assign out_ch.valid     = (rcnt_r != '0);
  assign out_ch.out_byte  = rbuf_r[0].out_byte;
  assign out_ch.frame_end = rbuf_r[0].frame_end;
  assign out_ch.status    = rbuf_r[0].status;
  assign in_ch.ready      = (rcnt_r == '0) ||
                            ((rcnt_r == CNT_W'(1)) && out_ch.ready);

  // The header CRC from zero is linear in its bytes, so it is the XOR of
  // four parallel table reads.
  assign hdr_crc = CRC_T3[in_ch.feature] ^ CRC_T2[in_ch.command] ^
                   CRC_T1[in_ch.frame_length[15:8]] ^ CRC_T0[in_ch.frame_length[7:0]];
  assign hdr_fin = hdr_crc ^ CRC_XOROUT;

  // Byte-wise table update for one payload byte.
  assign dat_crc = {8'h00, crc_r[15:8]} ^ CRC_T0[crc_r[7:0] ^ in_ch.payload_byte];
  assign dat_fin = dat_crc ^ CRC_XOROUT;
  assign bl_dec  = bytes_left_r - 16'd1;

  // Results and next state for the beat on the input.
  always_comb begin
    for (int i = 0; i < NUM_RES; i++) begin
      new_res[i] = '0;
    end
    new_cnt        = CNT_W'(1);
    crc_nxt        = crc_r;
    bytes_left_nxt = bytes_left_r;
    in_frame_nxt   = in_frame_r;
    case (in_ch.opcode)
      OP_START: begin
        if (in_ch.frame_length > MaxLen) begin
          new_res[0]     = '{out_byte: 8'h00, frame_end: 1'b1, status: ST_TOO_LONG};
          crc_nxt        = '0;
          bytes_left_nxt = '0;
          in_frame_nxt   = 1'b0;
        end else begin
          new_res[0]     = '{out_byte: in_ch.feature, frame_end: 1'b0, status: ST_OK};
          new_res[1]     = '{out_byte: in_ch.command, frame_end: 1'b0, status: ST_OK};
          new_res[2]     = '{out_byte: in_ch.frame_length[15:8], frame_end: 1'b0,
                             status: ST_OK};
          new_res[3]     = '{out_byte: in_ch.frame_length[7:0], frame_end: 1'b0,
                             status: ST_OK};
          new_cnt        = CNT_W'(4);
          crc_nxt        = hdr_crc;
          bytes_left_nxt = in_ch.frame_length;
          in_frame_nxt   = 1'b1;
          // An empty frame closes with its CRC straight away.
          if (in_ch.frame_length == 16'd0) begin
            new_res[4]   = '{out_byte: hdr_fin[15:8], frame_end: 1'b0, status: ST_OK};
            new_res[5]   = '{out_byte: hdr_fin[7:0], frame_end: 1'b1, status: ST_OK};
            new_cnt      = CNT_W'(6);
            in_frame_nxt = 1'b0;
          end
        end
      end
      OP_DATA: begin
        if (!in_frame_r) begin
          new_res[0] = '{out_byte: 8'h00, frame_end: 1'b1, status: ST_STRAY};
        end else begin
          new_res[0]     = '{out_byte: in_ch.payload_byte, frame_end: 1'b0, status: ST_OK};
          crc_nxt        = dat_crc;
          bytes_left_nxt = bl_dec;
          // The last payload byte is followed by the CRC.
          if (bl_dec == 16'd0) begin
            new_res[1]   = '{out_byte: dat_fin[15:8], frame_end: 1'b0, status: ST_OK};
            new_res[2]   = '{out_byte: dat_fin[7:0], frame_end: 1'b1, status: ST_OK};
            new_cnt      = CNT_W'(3);
            in_frame_nxt = 1'b0;
          end
        end
      end
      default: begin
        new_cnt = CNT_W'(1);
      end
    endcase
  end

  // Buffer loads on accept and shifts down by one beat on each pop.
  always_comb begin
    for (int i = 0; i < NUM_RES; i++) begin
      rbuf_nxt[i] = rbuf_r[i];
    end
    rcnt_nxt = rcnt_r;
    if (acc) begin
      for (int i = 0; i < NUM_RES; i++) begin
        rbuf_nxt[i] = new_res[i];
      end
      rcnt_nxt = new_cnt;
    end else if (pop) begin
      for (int i = 0; i < NUM_RES - 1; i++) begin
        rbuf_nxt[i] = rbuf_r[i + 1];
      end
      rcnt_nxt = rcnt_r - CNT_W'(1);
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_RES; i++) begin
      rbuf_r[i] <= rbuf_nxt[i];
    end
  end

  // Control and framing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r       <= '0;
      crc_r        <= '0;
      bytes_left_r <= '0;
      in_frame_r   <= 1'b0;
    end else begin
      rcnt_r <= rcnt_nxt;
      if (acc) begin
        crc_r        <= crc_nxt;
        bytes_left_r <= bytes_left_nxt;
        in_frame_r   <= in_frame_nxt;
      end
    end
  end

  // Every accepted beat leaves at least one result beat behind it.
  `CMPF_ASSERT_NEXT(a_acc_fills, acc, rcnt_r != '0, "accepted beat left no result")
  // The buffer never holds more beats than one input beat can cause.
  `CMPF_ASSERT_NOW(a_cnt_max, 1'b1, rcnt_r <= CNT_W'(NUM_RES), "result count overflow")
  // An open frame always expects at least one more payload byte.
  `CMPF_ASSERT_NOW(a_open_frame, in_frame_r, bytes_left_r != 16'd0, "open frame with no bytes left")
  // Error beats always close the frame.
  `CMPF_ASSERT_NOW(a_err_end, out_ch.valid && (out_ch.status != ST_OK), out_ch.frame_end, "error beat without frame_end")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the CRC-16/MAXIM packet framer core.
`timescale 1ns / 100ps

module tb;
  import cmpf_pkg::*;

  localparam int unsigned MAX_LEN    = 256;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_ITEMS  = 75;

  logic clk;
  logic rst_n;

  cmpf_in_if  in_bus ();
  cmpf_out_if out_bus ();

  crc16_maxim_packet_framer_core #(
    .MAX_PAYLOAD(MAX_LEN)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Framer state as the predictor sees it.
  logic [15:0] crc_acc;
  logic [15:0] pending_bytes;
  logic        frame_open;

  // Result beats still owed by the block, oldest first.
  res_t        owed_beats[$];

  int unsigned beats_sent;
  int unsigned err_count;
  int unsigned idle_cycles;
  logic        gaps_on;

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Reflected CRC-16 over one byte, polynomial 0xA001.
  function automatic logic [15:0] crc16_maxim_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic res_t frame_beat(input logic [7:0] b, input logic last,
                                      input logic [1:0] st);
    res_t r;
    r.out_byte  = b;
    r.frame_end = last;
    r.status    = st;
    return r;
  endfunction

  // A byte of header or payload goes out and into the CRC.
  task automatic owe_frame_byte(input logic [7:0] b);
    crc_acc = crc16_maxim_byte(crc_acc, b);
    owed_beats.push_back(frame_beat(b, 1'b0, ST_OK));
  endtask

  // The closing CRC, high byte first, ends the frame.
  task automatic owe_frame_crc();
    logic [15:0] c;
    c = crc_acc ^ 16'hFFFF;
    owed_beats.push_back(frame_beat(c[15:8], 1'b0, ST_OK));
    owed_beats.push_back(frame_beat(c[7:0], 1'b1, ST_OK));
    frame_open    = 1'b0;
    pending_bytes = '0;
  endtask

  // Work out the result beats that one accepted input beat causes.
  task automatic predict_framer(input logic op, input logic [7:0] feat,
                                input logic [7:0] cmd, input logic [15:0] len,
                                input logic [7:0] pb);
    if (op == OP_START) begin
      if (len > MAX_LEN) begin
        frame_open    = 1'b0;
        pending_bytes = '0;
        crc_acc       = '0;
        owed_beats.push_back(frame_beat(8'h00, 1'b1, ST_TOO_LONG));
      end else begin
        crc_acc = '0;
        owe_frame_byte(feat);
        owe_frame_byte(cmd);
        owe_frame_byte(len[15:8]);
        owe_frame_byte(len[7:0]);
        pending_bytes = len;
        frame_open    = 1'b1;
        if (len == 16'd0) begin
          owe_frame_crc();
        end
      end
    end else if (!frame_open) begin
      owed_beats.push_back(frame_beat(8'h00, 1'b1, ST_STRAY));
    end else begin
      owe_frame_byte(pb);
      pending_bytes = pending_bytes - 16'd1;
      if (pending_bytes == 16'd0) begin
        owe_frame_crc();
      end
    end
  endtask

  // Present one input beat, with an occasional gap first, and wait for it to
  // be taken. Valid stays high afterwards so back-to-back beats need no gap.
  task automatic send_beat(input logic op, input logic [7:0] feat,
                           input logic [7:0] cmd, input logic [15:0] len,
                           input logic [7:0] pb);
    while (gaps_on && ($urandom_range(99) < 11)) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= op;
    in_bus.feature      <= feat;
    in_bus.command      <= cmd;
    in_bus.frame_length <= len;
    in_bus.payload_byte <= pb;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    predict_framer(op, feat, cmd, len, pb);
    beats_sent++;
  endtask

  // Start beat with random header bytes; the payload field is noise.
  task automatic send_start(input logic [15:0] len);
    send_beat(OP_START, 8'($urandom), 8'($urandom), len, 8'($urandom));
  endtask

  // Data beat; the header fields are noise.
  task automatic send_data(input logic [7:0] b);
    send_beat(OP_DATA, 8'($urandom), 8'($urandom), 16'($urandom), b);
  endtask

  // Hold the input idle until every owed result beat has arrived.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (owed_beats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Header extremes, empty frames, over-long lengths, stray data and restarts.
  task automatic test_header_edges();
    send_beat(OP_START, 8'h00, 8'h00, 16'd0, 8'hFF);
    send_beat(OP_START, 8'hFF, 8'hFF, 16'd0, 8'h00);
    send_beat(OP_START, 8'hA5, 8'h5A, 16'd1, 8'h00);
    send_data(8'h00);
    send_beat(OP_START, 8'h00, 8'hFF, 16'd2, 8'h00);
    send_data(8'hFF);
    send_data(8'h80);
    send_beat(OP_START, 8'h12, 8'h34, 16'(MAX_LEN + 1), 8'h00);
    send_beat(OP_START, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_data(8'h3C);
    // A start beat part way through a frame drops it.
    send_start(16'd3);
    send_data(8'h11);
    send_start(16'd1);
    send_data(8'h22);
    // An over-long start abandons the open frame, so the next data is stray.
    send_start(16'd4);
    send_data(8'h33);
    send_start(16'd300);
    send_data(8'h44);
  endtask

  // One frame of the largest payload, sent from and back to an idle block.
  task automatic test_full_length();
    wait_drained();
    send_beat(OP_START, 8'hC3, 8'h3C, 16'(MAX_LEN), 8'h00);
    for (int i = 0; i < MAX_LEN; i++) begin
      send_data(8'($urandom));
    end
    wait_drained();
  endtask

  // Mostly well-formed frames of random content, with cut-short frames,
  // stray data and over-long lengths mixed in.
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    first = beats_sent;
    while (beats_sent - first < RAND_ITEMS) begin
      // A long stretch in the middle runs without any idling.
      gaps_on <= !((beats_sent - first > 20) && (beats_sent - first < 50));
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(99) < 80) ? $urandom_range(6) : $urandom_range(40, 7);
        send_start(16'(len));
        for (int i = 0; i < len; i++) begin
          send_data(8'($urandom));
        end
      end else if (pick < 80) begin
        len = $urandom_range(20, 2);
        cut = $urandom_range(len - 1);
        send_start(16'(len));
        for (int i = 0; i < cut; i++) begin
          send_data(8'($urandom));
        end
      end else if (pick < 88) begin
        send_data(8'($urandom));
      end else if (pick < 94) begin
        send_start(16'($urandom_range(16'hFFFF, MAX_LEN + 1)));
      end else begin
        send_start(16'($urandom_range(16'hFFFF, 16'hFE00)));
      end
    end
    gaps_on <= 1'b1;
  endtask

  // Check each result beat against the oldest owed one and drive the
  // result-side ready with random stalls.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (owed_beats.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("tb: unexpected result beat byte=%02h end=%0b status=%0d",
                   out_bus.out_byte, out_bus.frame_end, out_bus.status);
        end
      end else begin
        want = owed_beats.pop_front();
        if (out_bus.out_byte !== want.out_byte || out_bus.frame_end !== want.frame_end ||
            out_bus.status !== want.status) begin
          err_count++;
          if (err_count <= 10) begin
            $display("tb: mismatch exp byte=%02h end=%0b status=%0d, got byte=%02h end=%0b status=%0d",
                     want.out_byte, want.frame_end, want.status,
                     out_bus.out_byte, out_bus.frame_end, out_bus.status);
          end
        end
      end
    end
    out_bus.ready <= gaps_on ? ($urandom_range(99) >= 11) : 1'b1;
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    gaps_on             = 1'b1;
    beats_sent          = 0;
    err_count           = 0;
    crc_acc             = '0;
    pending_bytes       = '0;
    frame_open          = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.opcode       = OP_START;
    in_bus.feature      = '0;
    in_bus.command      = '0;
    in_bus.frame_length = '0;
    in_bus.payload_byte = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_edges();
    test_full_length();
    test_random_traffic();

    // Let everything drain, then watch a little longer for stray beats.
    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0 && owed_beats.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
